// File: rtl/bayer_directional_interpolation_unit_defines.svh
// assertion macros for the bayer directional interpolation unit
// used by the top level only; expects signals clk and arst_n in scope
`ifndef BAYER_DIRECTIONAL_INTERPOLATION_UNIT_DEFINES_SVH
`define BAYER_DIRECTIONAL_INTERPOLATION_UNIT_DEFINES_SVH

// condition must hold at every edge out of reset
`define BDI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BDI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bdi_pkg.sv
// shared types, constants and helper functions of the bayer interpolation unit
// no dependencies
`timescale 1ns / 1ps

package bdi_pkg;

	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LINES           = 6;
	localparam int WIN             = 7;
	localparam int POS_BITS        = 17;
	localparam int RB_BITS         = 22;
	localparam int G_BITS          = 20;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_CFA_PHASE    = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		SITE_RED   = 2'd0,
		SITE_BLUE  = 2'd1,
		SITE_GRN_R = 2'd2,
		SITE_GRN_B = 2'd3
	} site_t;

	// indexed by {phase, row parity, column parity}
	localparam site_t SITE_TAB [16] = '{
		SITE_RED,   SITE_GRN_R, SITE_GRN_B, SITE_BLUE,
		SITE_BLUE,  SITE_GRN_B, SITE_GRN_R, SITE_RED,
		SITE_GRN_R, SITE_RED,   SITE_BLUE,  SITE_GRN_B,
		SITE_GRN_B, SITE_BLUE,  SITE_RED,   SITE_GRN_R
	};

	function automatic site_t site_of(input logic [1:0] phase, input logic yp,
			input logic xp);
		return SITE_TAB[{phase, yp, xp}];
	endfunction

	// directional green in q4: median of estimate and the two green neighbours
	function automatic logic [19:0] green_q4(input logic [15:0] m, input logic [15:0] p,
			input logic [15:0] q, input logic [15:0] a, input logic [15:0] b,
			input logic is_green);
		logic signed [20:0] t;
		logic signed [20:0] lo4;
		logic signed [20:0] hi4;
		logic [15:0] lo;
		logic [15:0] hi;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		t = 21'sd2 * ($signed({5'd0, m}) + $signed({5'd0, p}) + $signed({5'd0, q}))
			- $signed({5'd0, a}) - $signed({5'd0, b});
		lo4 = $signed({3'd0, lo, 2'b00});
		hi4 = $signed({3'd0, hi, 2'b00});
		if (t < lo4) t = lo4;
		if (t > hi4) t = hi4;
		if (is_green)
			return {m, 4'b0000};
		return {t[17:0], 2'b00};
	endfunction

endpackage

// File: rtl/bayer_directional_interpolation_unit.sv
// top level of the bayer directional interpolation unit
// depends on bdi_pkg, bdi_line_store and the assertion macro header
`timescale 1ns / 1ps
`include "bayer_directional_interpolation_unit_defines.svh"

// usage
// - input channel in_valid/in_ready carries raw_sample and frame_start, one
//   sample per transfer in raster order; frame_start marks pixel (0,0)
// - output channel out_valid/out_ready carries horizontal and vertical rgb in
//   q4 for each pixel at least 3 from every edge; frame_last flags the final one
// - a result for pixel (y,x) leaves with the transfer of sample (y+3,x+3)
// - throughput one sample per cycle while the receiver takes results; out_valid
//   rises after the line bank read and stage 1 at the transfer edge, then
//   window shift, green estimates and colour fill, each into its own register
// - each pipeline stage has its own valid bit and moves when the next one is
//   free, so samples keep flowing while a result waits to be taken
// - a stalled receiver fills the stages and then drops in_ready
// - config is written through cfg_we/cfg_index/cfg_data while idle
// - reset clears position counters and stage valids; config resets to 4096x4096,
//   phase 0; line bank contents are undefined until written and need no clearing
module bayer_directional_interpolation_unit #(
	parameter int MAX_WIDTH   = bdi_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = bdi_pkg::SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        raw_sample,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [21:0] horiz_red,
	output logic [19:0]        horiz_green,
	output logic signed [21:0] horiz_blue,
	output logic signed [21:0] vert_red,
	output logic [19:0]        vert_green,
	output logic signed [21:0] vert_blue,
	output logic               frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = bdi_pkg::POS_BITS;
	localparam int SB = SAMPLE_BITS;

	// configuration registers
	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [1:0]  phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd4096;
			height_q <= 16'd4096;
			phase_q  <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdi_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data[12:0];
				bdi_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				bdi_pkg::CFG_CFA_PHASE:    phase_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// saturated frame size
	logic [PW-1:0] w_sat, h_sat;
	always_comb begin
		w_sat = PW'(width_q);
		if (width_q < 13'd8) w_sat = PW'(8);
		else if (PW'(width_q) > PW'(MAX_WIDTH)) w_sat = PW'(MAX_WIDTH);
		h_sat = (height_q < 16'd8) ? PW'(8) : PW'(height_q);
	end

	// stage handshakes
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic move1, move2, move3, accept;

	assign move3    = valid_s3 && (!out_valid_q || out_ready);
	assign move2    = valid_s2 && (!valid_s3 || move3);
	assign move1    = valid_s1 && (!valid_s2 || move2);
	assign in_ready = !valid_s1 || move1;
	assign accept   = in_valid && in_ready;

	// raster position, bank is row mod 6
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [2:0]    bank_q;
	logic [CW-1:0] c_cur;
	logic [15:0]   r_cur;
	logic [2:0]    b_cur;
	logic [PW-1:0] c_ext, r_ext;
	logic          emit_cur, last_cur;

	always_comb begin
		c_cur    = frame_start ? '0 : col_q;
		r_cur    = frame_start ? '0 : row_q;
		b_cur    = frame_start ? '0 : bank_q;
		c_ext    = PW'(c_cur);
		r_ext    = PW'(r_cur);
		emit_cur = (r_ext >= PW'(6)) && (c_ext >= PW'(6)) && (r_ext < h_sat) && (c_ext < w_sat);
		last_cur = (r_ext == h_sat - PW'(1)) && (c_ext == w_sat - PW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= '0;
		end else if (accept) begin
			if (c_ext + PW'(1) >= w_sat) begin
				col_q <= '0;
				if (r_ext + PW'(1) >= h_sat) begin
					row_q  <= '0;
					bank_q <= '0;
				end else begin
					row_q  <= r_cur + 16'd1;
					bank_q <= (b_cur == 3'(bdi_pkg::LINES - 1)) ? 3'd0 : b_cur + 3'd1;
				end
			end else begin
				// a frame start mid-line also restarts the row
				col_q  <= c_cur + CW'(1);
				row_q  <= r_cur;
				bank_q <= b_cur;
			end
		end
	end

	// line banks, read data lines up with stage 1
	logic [bdi_pkg::LINES-1:0][SB-1:0] rd_s1;

	bdi_line_store #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SB)
	) u_store (
		.clk   (clk),
		.en    (accept),
		.wbank (b_cur),
		.addr  (c_cur),
		.wdata (raw_sample[SB-1:0]),
		.rdata (rd_s1)
	);

	// stage 1: sample and position flags
	logic [SB-1:0] sample_s1;
	logic [2:0]    bank_s1;
	logic          emit_s1, last_s1, yp_s1, xp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= raw_sample[SB-1:0];
			bank_s1   <= b_cur;
			emit_s1   <= emit_cur;
			last_s1   <= last_cur;
			// centre sits three rows up and three columns left
			yp_s1     <= ~r_cur[0];
			xp_s1     <= ~c_cur[0];
		end
	end

	// stage 2: the 7x7 window
	logic [SB-1:0] win_s2 [bdi_pkg::WIN][bdi_pkg::WIN];
	logic          emit_s2, last_s2, yp_s2, xp_s2;
	logic [3:0]    rsum [bdi_pkg::LINES];
	logic [2:0]    rsel [bdi_pkg::LINES];

	always_comb begin
		for (int k = 0; k < bdi_pkg::LINES; k++) begin
			rsum[k] = 4'(bank_s1) + 4'(k);
			rsel[k] = (rsum[k] >= 4'(bdi_pkg::LINES))
				? 3'(rsum[k] - 4'(bdi_pkg::LINES)) : rsum[k][2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || move2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			for (int y = 0; y < bdi_pkg::WIN; y++) begin
				for (int x = 0; x < bdi_pkg::WIN - 1; x++) begin
					win_s2[y][x] <= win_s2[y][x+1];
				end
			end
			for (int k = 0; k < bdi_pkg::LINES; k++) begin
				win_s2[k][bdi_pkg::WIN-1] <= rd_s1[rsel[k]];
			end
			win_s2[bdi_pkg::WIN-1][bdi_pkg::WIN-1] <= sample_s1;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			yp_s2   <= yp_s1;
			xp_s2   <= xp_s1;
		end
	end

	// stage 3: greens per direction over the 3x3 around the centre
	logic [19:0] gh_c [3][3];
	logic [19:0] gv_c [3][3];
	logic [19:0] gh_s3 [3][3];
	logic [19:0] gv_s3 [3][3];
	logic [15:0] px_s3 [3][3];
	logic        emit_s3, last_s3, yp_s3, xp_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				logic isg;
				isg = (bdi_pkg::site_of(phase_q, yp_s2 ^ i[0] ^ 1'b1, xp_s2 ^ j[0] ^ 1'b1)
					== bdi_pkg::SITE_GRN_R)
					|| (bdi_pkg::site_of(phase_q, yp_s2 ^ i[0] ^ 1'b1, xp_s2 ^ j[0] ^ 1'b1)
					== bdi_pkg::SITE_GRN_B);
				gh_c[i][j] = bdi_pkg::green_q4(16'(win_s2[2+i][2+j]),
					16'(win_s2[2+i][1+j]), 16'(win_s2[2+i][3+j]),
					16'(win_s2[2+i][j]), 16'(win_s2[2+i][4+j]), isg);
				gv_c[i][j] = bdi_pkg::green_q4(16'(win_s2[2+i][2+j]),
					16'(win_s2[1+i][2+j]), 16'(win_s2[3+i][2+j]),
					16'(win_s2[i][2+j]), 16'(win_s2[4+i][2+j]), isg);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!valid_s3 || move3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					gh_s3[i][j] <= gh_c[i][j];
					gv_s3[i][j] <= gv_c[i][j];
					px_s3[i][j] <= 16'(win_s2[2+i][2+j]);
				end
			end
			emit_s3 <= emit_s2;
			last_s3 <= last_s2;
			yp_s3   <= yp_s2;
			xp_s3   <= xp_s2;
		end
	end

	// colour fill from differences to each direction's green
	logic signed [23:0] dh [3][3];
	logic signed [23:0] dv [3][3];
	logic signed [23:0] gch, gcv, pc;
	logic signed [23:0] diag_h, diag_v, hp_h, hp_v, vp_h, vp_v;
	logic signed [23:0] s4h, s4v, s2hh, s2hv, s2vh, s2vv;
	logic signed [23:0] hr_c, hb_c, vr_c, vb_c;
	bdi_pkg::site_t     site_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				dh[i][j] = $signed({4'd0, px_s3[i][j], 4'd0}) - $signed({4'd0, gh_s3[i][j]});
				dv[i][j] = $signed({4'd0, px_s3[i][j], 4'd0}) - $signed({4'd0, gv_s3[i][j]});
			end
		end
		gch  = $signed({4'd0, gh_s3[1][1]});
		gcv  = $signed({4'd0, gv_s3[1][1]});
		pc   = $signed({4'd0, px_s3[1][1], 4'd0});
		// differences are multiples of four, so the shifts are exact
		s4h  = dh[0][0] + dh[2][2] + dh[2][0] + dh[0][2];
		s4v  = dv[0][0] + dv[2][2] + dv[2][0] + dv[0][2];
		s2hh = dh[1][0] + dh[1][2];
		s2hv = dv[1][0] + dv[1][2];
		s2vh = dh[0][1] + dh[2][1];
		s2vv = dv[0][1] + dv[2][1];
		diag_h = s4h >>> 2;
		diag_v = s4v >>> 2;
		hp_h   = s2hh >>> 1;
		hp_v   = s2hv >>> 1;
		vp_h   = s2vh >>> 1;
		vp_v   = s2vv >>> 1;
		site_c = bdi_pkg::site_of(phase_q, yp_s3, xp_s3);
		unique case (site_c)
			bdi_pkg::SITE_RED: begin
				hr_c = pc;          hb_c = gch + diag_h;
				vr_c = pc;          vb_c = gcv + diag_v;
			end
			bdi_pkg::SITE_BLUE: begin
				hb_c = pc;          hr_c = gch + diag_h;
				vb_c = pc;          vr_c = gcv + diag_v;
			end
			bdi_pkg::SITE_GRN_R: begin
				hr_c = gch + hp_h;  hb_c = gch + vp_h;
				vr_c = gcv + hp_v;  vb_c = gcv + vp_v;
			end
			default: begin
				hb_c = gch + hp_h;  hr_c = gch + vp_h;
				vb_c = gcv + hp_v;  vr_c = gcv + vp_v;
			end
		endcase
	end

	// output register
	logic signed [21:0] hr_q, hb_q, vr_q, vb_q;
	logic [19:0]        hg_q, vg_q;
	logic               last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s3 && emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (move3) begin
			hr_q   <= hr_c[21:0];
			hb_q   <= hb_c[21:0];
			vr_q   <= vr_c[21:0];
			vb_q   <= vb_c[21:0];
			hg_q   <= gh_s3[1][1];
			vg_q   <= gv_s3[1][1];
			last_q <= last_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign horiz_red   = hr_q;
	assign horiz_green = hg_q;
	assign horiz_blue  = hb_q;
	assign vert_red    = vr_q;
	assign vert_green  = vg_q;
	assign vert_blue   = vb_q;
	assign frame_last  = last_q;

	// checks on the pipeline and position logic
	`BDI_ASSERT_ALWAYS(a_bank_range, bank_q < 3'(bdi_pkg::LINES), "line bank index out of range")
	`BDI_ASSERT_NEXT(a_s3_hold, valid_s3 && !move3, valid_s3, "stage 3 item lost while stalled")
	`BDI_ASSERT_NEXT(a_frame_restart, accept && frame_start, col_q == CW'(1) && row_q == 16'd0,
		"frame start did not restart the raster position")

endmodule

// File: rtl/bdi_line_store.sv
// six raw line banks: on en all are read, only bank wbank is written
// depends on bdi_pkg
`timescale 1ns / 1ps

module bdi_line_store #(
	parameter int MAX_WIDTH   = bdi_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = bdi_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [2:0]                                 wbank,
	input  logic [$clog2(MAX_WIDTH)-1:0]               addr,
	input  logic [SAMPLE_BITS-1:0]                     wdata,
	output logic [bdi_pkg::LINES-1:0][SAMPLE_BITS-1:0] rdata
);

	for (genvar g = 0; g < bdi_pkg::LINES; g++) begin : g_bank
		logic [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

		// read-first: the old entry comes out while the new one goes in
		always_ff @(posedge clk) begin
			if (en) begin
				rdata[g] <= mem[addr];
				if (wbank == 3'(g))
					mem[addr] <= wdata;
			end
		end
	end

endmodule

// File: test/tb_bayer_directional_interpolation_unit.sv
// self-checking testbench of the bayer directional interpolation unit
// drives raster frames under random idling and checks every rgb result
// depends on bdi_pkg and the unit's top level
`timescale 1ns / 1ps

module tb_bayer_directional_interpolation_unit;

	localparam int STORE_W   = 4096;
	localparam int WDOG_MAX  = 4000;

	typedef struct {
		logic [15:0] sample;
		logic        sof;
	} pix_t;

	typedef struct {
		logic [21:0] hr;
		logic [19:0] hg;
		logic [21:0] hb;
		logic [21:0] vr;
		logic [19:0] vg;
		logic [21:0] vb;
		logic        last;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = bdi_pkg::CFG_FRAME_WIDTH;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] raw_sample = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [21:0] horiz_red, horiz_blue, vert_red, vert_blue;
	logic [19:0] horiz_green, vert_green;
	logic frame_last;

	bayer_directional_interpolation_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_sample(raw_sample), .frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.horiz_red(horiz_red), .horiz_green(horiz_green), .horiz_blue(horiz_blue),
		.vert_red(vert_red), .vert_green(vert_green), .vert_blue(vert_blue),
		.frame_last(frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and expectation stores
	pix_t pending_pix[$];
	rgb_t rgb_due[$];
	int   n_fail = 0;
	bit   no_idle = 1'b0;
	bit   in_took = 1'b0;
	bit   out_took = 1'b0;
	int   in_gap = 0;
	int   out_gap = 0;
	int   stall_cycles = 0;

	// predictor state: registers, line store, position and window
	logic [12:0] p_width = 13'd4096;
	logic [15:0] p_height = 16'd4096;
	logic [1:0]  p_phase = 2'd0;
	bit [15:0]   line_mem [bdi_pkg::LINES][STORE_W];
	int unsigned row_pos = 0, col_pos = 0;
	longint      wnd [bdi_pkg::WIN][bdi_pkg::WIN];
	int          cy, cx;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	// colour of the site at an offset from the window centre
	function automatic bdi_pkg::site_t site_off(int dy, int dx);
		bdi_pkg::site_t tab [4][4];
		int y, x;
		tab[0] = '{bdi_pkg::SITE_RED, bdi_pkg::SITE_GRN_R, bdi_pkg::SITE_GRN_B,
			bdi_pkg::SITE_BLUE};
		tab[1] = '{bdi_pkg::SITE_BLUE, bdi_pkg::SITE_GRN_B, bdi_pkg::SITE_GRN_R,
			bdi_pkg::SITE_RED};
		tab[2] = '{bdi_pkg::SITE_GRN_R, bdi_pkg::SITE_RED, bdi_pkg::SITE_BLUE,
			bdi_pkg::SITE_GRN_B};
		tab[3] = '{bdi_pkg::SITE_GRN_B, bdi_pkg::SITE_BLUE, bdi_pkg::SITE_RED,
			bdi_pkg::SITE_GRN_R};
		y = (cy + dy + 4) & 1;
		x = (cx + dx + 4) & 1;
		return tab[p_phase][y * 2 + x];
	endfunction

	function automatic longint pxl(int dy, int dx);
		return wnd[3 + dy][3 + dx];
	endfunction

	// green per direction in q4, clamped between the two green neighbours
	function automatic longint dir_green(int dy, int dx, bit vert);
		int ey, ex;
		longint p, q, v, lo, hi;
		ey = vert ? 1 : 0;
		ex = vert ? 0 : 1;
		if (site_off(dy, dx) inside {bdi_pkg::SITE_GRN_R, bdi_pkg::SITE_GRN_B})
			return 16 * pxl(dy, dx);
		p = pxl(dy - ey, dx - ex);
		q = pxl(dy + ey, dx + ex);
		v = 4 * (2 * (pxl(dy, dx) + p + q) - pxl(dy - 2 * ey, dx - 2 * ex)
			- pxl(dy + 2 * ey, dx + 2 * ex));
		lo = 16 * ((p < q) ? p : q);
		hi = 16 * ((p < q) ? q : p);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic longint cdiff(int dy, int dx, bit vert);
		return 16 * pxl(dy, dx) - dir_green(dy, dx, vert);
	endfunction

	task automatic fill_rgb(bit vert, output longint r, output longint g,
			output longint b);
		longint gc, diag, hp, vp;
		gc = dir_green(0, 0, vert);
		diag = (cdiff(-1, -1, vert) + cdiff(1, 1, vert) + cdiff(1, -1, vert)
			+ cdiff(-1, 1, vert)) / 4;
		hp = (cdiff(0, -1, vert) + cdiff(0, 1, vert)) / 2;
		vp = (cdiff(-1, 0, vert) + cdiff(1, 0, vert)) / 2;
		g = gc;
		case (site_off(0, 0))
			bdi_pkg::SITE_RED: begin
				r = 16 * pxl(0, 0);
				b = gc + diag;
			end
			bdi_pkg::SITE_BLUE: begin
				b = 16 * pxl(0, 0);
				r = gc + diag;
			end
			bdi_pkg::SITE_GRN_R: begin
				r = gc + hp;
				b = gc + vp;
			end
			default: begin
				b = gc + hp;
				r = gc + vp;
			end
		endcase
	endtask

	// advance the predictor by one accepted sample
	task automatic predict_pixel(pix_t px);
		int unsigned w, h, r, c;
		longint hr, hg, hb, vr, vg, vb;
		rgb_t res;
		w = p_width;
		h = p_height;
		if (w < 8) w = 8;
		if (w > STORE_W) w = STORE_W;
		if (h < 8) h = 8;
		if (px.sof) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		for (int y = 0; y < bdi_pkg::WIN; y++)
			for (int x = 0; x < bdi_pkg::WIN - 1; x++)
				wnd[y][x] = wnd[y][x + 1];
		for (int k = 0; k < bdi_pkg::LINES; k++)
			wnd[k][bdi_pkg::WIN - 1] = (c < STORE_W)
				? line_mem[(r + k) % bdi_pkg::LINES][c] : 0;
		wnd[bdi_pkg::WIN - 1][bdi_pkg::WIN - 1] = px.sample;
		if (c < STORE_W)
			line_mem[r % bdi_pkg::LINES][c] = px.sample;
		if (r >= 6 && c >= 6 && r < h && c < w) begin
			cy = (r + 1) & 1;
			cx = (c + 1) & 1;
			fill_rgb(1'b0, hr, hg, hb);
			fill_rgb(1'b1, vr, vg, vb);
			res.hr = hr[21:0];
			res.hg = hg[19:0];
			res.hb = hb[21:0];
			res.vr = vr[21:0];
			res.vg = vg[19:0];
			res.vb = vb[21:0];
			res.last = (r == h - 1 && c == w - 1);
			rgb_due.push_back(res);
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// sample side: both transfers are seen at the rising edge
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_pixel('{raw_sample, frame_start});
				in_took = 1'b1;
			end
			if (out_valid && out_ready) begin
				out_took = 1'b1;
				if (rgb_due.size() == 0) begin
					$error("result with nothing expected");
					n_fail++;
				end else begin
					want = rgb_due.pop_front();
					if (horiz_red !== want.hr) begin
						$error("horiz_red exp %h got %h", want.hr, horiz_red);
						n_fail++;
					end
					if (horiz_green !== want.hg) begin
						$error("horiz_green exp %h got %h", want.hg, horiz_green);
						n_fail++;
					end
					if (horiz_blue !== want.hb) begin
						$error("horiz_blue exp %h got %h", want.hb, horiz_blue);
						n_fail++;
					end
					if (vert_red !== want.vr) begin
						$error("vert_red exp %h got %h", want.vr, vert_red);
						n_fail++;
					end
					if (vert_green !== want.vg) begin
						$error("vert_green exp %h got %h", want.vg, vert_green);
						n_fail++;
					end
					if (vert_blue !== want.vb) begin
						$error("vert_blue exp %h got %h", want.vb, vert_blue);
						n_fail++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last exp %b got %b", want.last, frame_last);
						n_fail++;
					end
				end
			end
			// watchdog: outstanding work but no transfer this cycle
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(pending_pix.size() == 0 && !in_valid && rgb_due.size() == 0))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WDOG_MAX) begin
				$display("tb_bayer_directional_interpolation_unit: FAIL");
				$finish;
			end
		end
	end

	// sample driver: holds each transfer until taken, then waits its gap
	always @(negedge clk) begin
		pix_t nxt;
		if (arst_n && !(in_valid && !in_took)) begin
			in_took = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_pix.size() != 0) begin
				nxt = pending_pix.pop_front();
				raw_sample <= nxt.sample;
				frame_start <= nxt.sof;
				in_valid <= 1'b1;
				in_gap = draw_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: a fresh stall drawn after every transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				out_took = 1'b0;
				out_gap = draw_gap();
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(bdi_pkg::cfg_index_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bdi_pkg::CFG_FRAME_WIDTH:  p_width = val[12:0];
			bdi_pkg::CFG_FRAME_HEIGHT: p_height = val;
			default:                   p_phase = val[1:0];
		endcase
	endtask

	// wait until every result is in, then let the pipeline empty
	task automatic settle();
		wait (pending_pix.size() == 0 && !in_valid && rgb_due.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	// kind: 0 random, 1 extremes in a checker, 2 ramp
	task automatic queue_samples(int n, bit sof_first, int kind);
		pix_t p;
		for (int i = 0; i < n; i++) begin
			case (kind)
				1: p.sample = ((i ^ (i >> 3)) & 1) ? 16'hFFFF : 16'h0000;
				2: p.sample = 16'(i * 1021);
				default: p.sample = 16'($urandom);
			endcase
			p.sof = sof_first && (i == 0);
			pending_pix.push_back(p);
		end
	endtask

	task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] ph);
		write_reg(bdi_pkg::CFG_FRAME_WIDTH, w);
		write_reg(bdi_pkg::CFG_FRAME_HEIGHT, h);
		write_reg(bdi_pkg::CFG_CFA_PHASE, ph);
	endtask

	initial begin
		int w, h, n;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: every cfa phase, smallest frames, extremes, a ramp at phase 3
		for (int ph = 0; ph < 4; ph++) begin
			set_frame(16'd8, 16'd8, 16'(ph));
			queue_samples(64, 1'b1, ph == 3 ? 2 : 1);
			settle();
		end
		// width and height below range saturate up to eight
		set_frame(16'd0, 16'd3, 16'd3);
		queue_samples(64, 1'b1, 1);
		settle();

		// random frames, mostly well formed, with some noise
		for (int phs = 0; phs < 4; phs++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			w = $urandom_range(8, 20);
			h = $urandom_range(8, 13);
			set_frame(16'(w), 16'(h), 16'($urandom_range(0, 3)));
			n = $urandom_range(1, 2);
			for (int f = 0; f < n; f++) begin
				case ($urandom_range(0, 5))
					0: queue_samples($urandom_range(1, w * h - 1), 1'b1, 0);
					// overrun: wrap into the next frame without a start mark
					1: queue_samples(w * h + $urandom_range(1, w * 8), 1'b1, 0);
					2: begin
						for (int i = 0; i < w * h; i++)
							pending_pix.push_back('{16'($urandom),
								1'($urandom_range(0, 40) == 0) || i == 0});
					end
					default: queue_samples(w * h, 1'b1, 0);
				endcase
			end
			settle();
		end
		no_idle = 1'b0;

		// tall frame cut short by a size shrink
		set_frame(16'd9, 16'hFFFF, 16'd1);
		queue_samples(9 * 10 + 7, 1'b1, 0);
		settle();
		// row now lies past the new size: no result for the next sample, which wraps
		set_frame(16'd8, 16'd8, 16'd2);
		queue_samples(8 * 9, 1'b0, 0);
		queue_samples(64, 1'b1, 0);
		settle();

		// widest line, with a register value above range: the first row only
		no_idle = 1'b1;
		set_frame(16'hFFFF, 16'd8, 16'd0);
		queue_samples(160, 1'b1, 0);
		settle();
		no_idle = 1'b0;
		set_frame(16'd4096, 16'd8, 16'd3);
		queue_samples(160, 1'b1, 0);
		settle();

		if (n_fail == 0)
			$display("tb_bayer_directional_interpolation_unit: PASS");
		else
			$display("tb_bayer_directional_interpolation_unit: FAIL");
		$finish;
	end

endmodule
